@@ sv/agg_pkg.sv @@
// shared types and constants for the arrow glyph generator
// no dependencies; imported by every module of the block
package agg_pkg;

  // coordinate and intermediate widths
  localparam int COORD_W = 32;
  localparam int DELTA_W = COORD_W + 1;
  localparam int MAG_W   = 31;
  localparam int SH_W    = 2;
  localparam int UNIT_W  = 31;
  localparam int ROOT_W  = 32;
  localparam int LEN_W   = 34;
  localparam int BARB_W  = 34;
  localparam int GEO_W   = 38;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BARB_RATIO     = 2'd2;

  localparam logic [15:0] MIN_LENGTH_RST     = 16'd0;
  localparam logic [30:0] PARALLEL_LIMIT_RST = 31'd1063004405;
  localparam logic [16:0] BARB_RATIO_RST     = 17'd16384;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic [15:0] min_length;
    logic [30:0] parallel_limit;
    logic [16:0] barb_ratio;
  } cfg_t;

  // one classified segment, front to back
  typedef struct packed {
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][COORD_W-1:0] t;
    logic [2:0][MAG_W-1:0]   m;
    logic [2:0]              neg;
    logic [SH_W-1:0]         sh;
  } entry_t;

endpackage

@@ sv/agg_front.sv @@
// front end: accepts a segment, forms delta magnitudes, signs and prescale shift
// depends on agg_pkg
module agg_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  agg_pkg::coord_t start_x,
  input  agg_pkg::coord_t start_y,
  input  agg_pkg::coord_t start_z,
  input  agg_pkg::coord_t tip_x,
  input  agg_pkg::coord_t tip_y,
  input  agg_pkg::coord_t tip_z,
  input  logic           full,
  output logic           push,
  output agg_pkg::entry_t entry
);
  import agg_pkg::*;

  logic [COORD_W-1:0] s [3];
  logic [COORD_W-1:0] t [3];
  logic [DELTA_W-1:0] diff [3];
  logic [DELTA_W-1:0] dmag [3];
  logic [DELTA_W-1:0] big;
  logic [SH_W-1:0]    sh;

  assign s[0] = start_x;
  assign s[1] = start_y;
  assign s[2] = start_z;
  assign t[0] = tip_x;
  assign t[1] = tip_y;
  assign t[2] = tip_z;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  // delta magnitudes and the largest one
  always_comb begin
    big = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {t[i][COORD_W-1], t[i]} - {s[i][COORD_W-1], s[i]};
      dmag[i] = diff[i][DELTA_W-1] ? (~diff[i] + 1'b1) : diff[i];
      if (dmag[i] > big) big = dmag[i];
    end
  end

  // shift so every magnitude fits below 2^31
  always_comb begin
    if (big[DELTA_W-1]) sh = 2'd2;
    else if (big[DELTA_W-2]) sh = 2'd1;
    else sh = 2'd0;
  end

  // classified word
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      entry.s[i]   = s[i];
      entry.t[i]   = t[i];
      entry.neg[i] = diff[i][DELTA_W-1];
      entry.m[i]   = MAG_W'(dmag[i] >> sh);
    end
    entry.sh = sh;
  end

endmodule

@@ sv/agg_fifo.sv @@
// two-entry queue between front and back end
// depends on agg_pkg
module agg_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  agg_pkg::entry_t din,
  output logic            full,
  input  logic            pop,
  output agg_pkg::entry_t dout,
  output logic            empty
);
  import agg_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/agg_back.sv @@
// back end: sequencer with shared multiplier, root and divide units, output register
// depends on agg_pkg
module agg_back #(
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  agg_pkg::cfg_t         cfg,
  input  logic                  empty,
  input  agg_pkg::entry_t       din,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output agg_pkg::coord_t       end_ax,
  output agg_pkg::coord_t       end_ay,
  output agg_pkg::coord_t       end_az,
  output agg_pkg::coord_t       end_bx,
  output agg_pkg::coord_t       end_by,
  output agg_pkg::coord_t       end_bz,
  output logic [INDEX_BITS-1:0] base_index,
  output logic                  last_line
);
  import agg_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_LEN   = 4'd3;
  localparam logic [3:0] S_EMIT0 = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PSEL  = 4'd6;
  localparam logic [3:0] S_PSQ   = 4'd7;
  localparam logic [3:0] S_PCHK  = 4'd8;
  localparam logic [3:0] S_BARB  = 4'd9;
  localparam logic [3:0] S_GEOM  = 4'd10;
  localparam logic [3:0] S_EMIT1 = 4'd11;
  localparam logic [3:0] S_EMIT2 = 4'd12;

  localparam logic signed [GEO_W-1:0] C_MAX = GEO_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [GEO_W-1:0] C_MIN = -C_MAX - GEO_W'(1);

  function automatic coord_t clamp(input logic signed [GEO_W-1:0] v);
    if (v > C_MAX) return C_MAX[COORD_W-1:0];
    else if (v < C_MIN) return C_MIN[COORD_W-1:0];
    else return v[COORD_W-1:0];
  endfunction

  logic [3:0] state;
  logic [2:0] ph;
  logic [1:0] k;
  logic [4:0] cnt;
  logic       root_sel;
  logic       div_sel;

  // segment
  coord_t          s_r [3];
  coord_t          t_r [3];
  mag_t            m_r [3];
  logic [2:0]      neg_r;
  logic [SH_W-1:0] sh_r;

  // multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] m30;

  // root unit
  logic [63:0]       sq_val;
  logic [33:0]       sq_rem;
  logic [ROOT_W-1:0] sq_root;
  logic [35:0]       sq_cand;
  logic [35:0]       sq_trial;
  logic              sq_ge;
  logic [33:0]       sq_rem_next;
  logic [ROOT_W-1:0] sq_root_next;

  // divide unit
  logic [31:0]       dv_rem;
  logic [31:0]       dv_d;
  logic [UNIT_W-1:0] dv_q;
  logic [32:0]       dv_cand;
  logic              dv_ge;
  logic [31:0]       dv_rem_next;
  logic [UNIT_W-1:0] dv_q_next;

  // geometry
  logic [ROOT_W-1:0] r_r;
  logic [ROOT_W-1:0] nroot;
  logic [LEN_W-1:0]  len_r;
  logic              short_r;
  logic [LEN_W-1:0]  len_calc;
  unit_t             dq [3];
  unit_t             pq [2];
  unit_t             pmag [3];
  logic [2:0]        pneg;
  unit_t             pa_m;
  unit_t             pb_m;
  logic              pa_neg;
  logic              pb_neg;
  logic              hx;
  logic [BARB_W-1:0] barb_r;
  logic [BARB_W-2:0] half;
  logic [34:0]       backm;
  logic [33:0]       sidem;
  coord_t            b1 [3];
  coord_t            b2 [3];
  coord_t            tk;
  logic signed [GEO_W-1:0] t_ext;
  logic signed [GEO_W-1:0] back_s;
  logic signed [GEO_W-1:0] side_s;
  logic signed [GEO_W-1:0] bt;

  // output register
  coord_t                a_o [3];
  coord_t                b_o [3];
  logic [INDEX_BITS-1:0] vertex_count;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && !empty;
  assign half     = barb_r[BARB_W-1:1];
  assign m30      = (acc + (prod >> 16)) >> 14;
  assign len_calc = LEN_W'({2'b00, r_r} << sh_r);

  assign end_ax = a_o[0];
  assign end_ay = a_o[1];
  assign end_az = a_o[2];
  assign end_bx = b_o[0];
  assign end_by = b_o[1];
  assign end_bz = b_o[2];

  // side vector placement by helper axis
  assign pmag[0] = hx ? '0 : pq[0];
  assign pmag[1] = hx ? pq[0] : '0;
  assign pmag[2] = pq[1];
  assign pneg    = {pb_neg, pa_neg, pa_neg};

  // one root bit per cycle
  always_comb begin
    sq_cand      = {sq_rem, sq_val[63:62]};
    sq_trial     = {2'b00, sq_root, 2'b01};
    sq_ge        = sq_cand >= sq_trial;
    sq_rem_next  = sq_ge ? 34'(sq_cand - sq_trial) : 34'(sq_cand);
    sq_root_next = {sq_root[ROOT_W-2:0], sq_ge};
  end

  // one quotient bit per cycle, first step unshifted
  always_comb begin
    dv_cand     = (cnt == 5'd0) ? {1'b0, dv_rem} : {dv_rem, 1'b0};
    dv_ge       = dv_cand >= {1'b0, dv_d};
    dv_rem_next = dv_ge ? 32'(dv_cand - {1'b0, dv_d}) : dv_cand[31:0];
    dv_q_next   = {dv_q[UNIT_W-2:0], dv_ge};
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        if (ph == 3'd0) mul_a = {1'b0, m_r[0]};
        else if (ph == 3'd1) mul_a = {1'b0, m_r[1]};
        else mul_a = {1'b0, m_r[2]};
        mul_b = mul_a;
      end
      S_PSQ: begin
        mul_a = (ph == 3'd0) ? {1'b0, pa_m} : {1'b0, pb_m};
        mul_b = mul_a;
      end
      S_BARB: begin
        mul_a = (ph == 3'd0) ? {14'd0, len_r[33:16]} : {16'd0, len_r[15:0]};
        mul_b = {15'd0, cfg.barb_ratio};
      end
      S_GEOM: begin
        case (ph)
          3'd0: begin
            mul_a = {1'b0, dq[k]};
            mul_b = {14'd0, barb_r[33:16]};
          end
          3'd1: begin
            mul_a = {1'b0, dq[k]};
            mul_b = {16'd0, barb_r[15:0]};
          end
          3'd2: begin
            mul_a = {1'b0, pmag[k]};
            mul_b = {15'd0, half[32:16]};
          end
          3'd3: begin
            mul_a = {1'b0, pmag[k]};
            mul_b = {16'd0, half[15:0]};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // barb endpoint arithmetic for coordinate k
  always_comb begin
    tk     = t_r[k];
    t_ext  = $signed({{(GEO_W-COORD_W){tk[COORD_W-1]}}, tk});
    back_s = neg_r[k] ? -$signed({3'b000, backm}) : $signed({3'b000, backm});
    side_s = pneg[k] ? -$signed({4'b0000, sidem}) : $signed({4'b0000, sidem});
    bt     = t_ext - back_s;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ph           <= '0;
      k            <= '0;
      cnt          <= '0;
      root_sel     <= 1'b0;
      div_sel      <= 1'b0;
      out_valid    <= 1'b0;
      vertex_count <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            for (int i = 0; i < 3; i++) begin
              s_r[i] <= din.s[i];
              t_r[i] <= din.t[i];
              m_r[i] <= din.m[i];
            end
            neg_r <= din.neg;
            sh_r  <= din.sh;
            ph    <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          ph <= ph + 3'd1;
          if (ph == 3'd1) acc <= prod;
          else if (ph == 3'd2) acc <= acc + prod;
          else if (ph == 3'd3) begin
            sq_val   <= acc + prod;
            sq_rem   <= '0;
            sq_root  <= '0;
            cnt      <= '0;
            root_sel <= 1'b0;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          sq_val  <= sq_val << 2;
          sq_rem  <= sq_rem_next;
          sq_root <= sq_root_next;
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (root_sel) begin
              nroot <= sq_root_next;
              state <= S_PCHK;
            end else begin
              r_r   <= sq_root_next;
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          len_r   <= len_calc;
          short_r <= (r_r == '0) || (len_calc <= {18'd0, cfg.min_length});
          state   <= S_EMIT0;
        end
        S_EMIT0: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) begin
              a_o[i] <= s_r[i];
              b_o[i] <= t_r[i];
            end
            base_index   <= vertex_count;
            last_line    <= short_r;
            out_valid    <= 1'b1;
            vertex_count <= vertex_count + INDEX_BITS'(2);
            if (short_r) state <= S_IDLE;
            else begin
              dv_rem  <= {1'b0, m_r[0]};
              dv_d    <= r_r;
              dv_q    <= '0;
              cnt     <= '0;
              k       <= '0;
              div_sel <= 1'b0;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dv_rem <= dv_rem_next;
          dv_q   <= dv_q_next;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            cnt  <= '0;
            dv_q <= '0;
            if (!div_sel) begin
              dq[k] <= dv_q_next;
              if (k == 2'd2) state <= S_PSEL;
              else begin
                k      <= k + 2'd1;
                dv_rem <= (k == 2'd0) ? {1'b0, m_r[1]} : {1'b0, m_r[2]};
              end
            end else begin
              pq[k[0]] <= dv_q_next;
              if (k == 2'd1) begin
                ph    <= '0;
                state <= S_BARB;
              end else begin
                k      <= k + 2'd1;
                dv_rem <= {1'b0, pb_m};
              end
            end
          end
        end
        S_PSEL: begin
          hx <= dq[1] > cfg.parallel_limit;
          pa_m <= dq[2];
          if (dq[1] > cfg.parallel_limit) begin
            pa_neg <= neg_r[2];
            pb_m   <= dq[1];
            pb_neg <= !neg_r[1];
          end else begin
            pa_neg <= !neg_r[2];
            pb_m   <= dq[0];
            pb_neg <= neg_r[0];
          end
          ph    <= '0;
          state <= S_PSQ;
        end
        S_PSQ: begin
          ph <= ph + 3'd1;
          if (ph == 3'd1) acc <= prod;
          else if (ph == 3'd2) begin
            sq_val   <= acc + prod;
            sq_rem   <= '0;
            sq_root  <= '0;
            cnt      <= '0;
            root_sel <= 1'b1;
            state    <= S_ROOT;
          end
        end
        S_PCHK: begin
          if (nroot == '0) begin
            pq[0] <= '0;
            pq[1] <= '0;
            ph    <= '0;
            state <= S_BARB;
          end else begin
            dv_rem  <= {1'b0, pa_m};
            dv_d    <= nroot;
            dv_q    <= '0;
            cnt     <= '0;
            k       <= '0;
            div_sel <= 1'b1;
            state   <= S_DIV;
          end
        end
        S_BARB: begin
          ph <= ph + 3'd1;
          if (ph == 3'd1) acc <= prod;
          else if (ph == 3'd2) begin
            barb_r <= BARB_W'(acc + (prod >> 16));
            ph     <= '0;
            k      <= '0;
            state  <= S_GEOM;
          end
        end
        S_GEOM: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd1: acc <= prod;
            3'd2: backm <= 35'(m30);
            3'd3: acc <= prod;
            3'd4: sidem <= 34'(m30);
            3'd5: begin
              b1[k] <= clamp(bt + side_s);
              b2[k] <= clamp(bt - side_s);
              ph    <= '0;
              if (k == 2'd2) state <= S_EMIT1;
              else k <= k + 2'd1;
            end
            default: acc <= acc;
          endcase
        end
        S_EMIT1: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) begin
              a_o[i] <= t_r[i];
              b_o[i] <= b1[i];
            end
            base_index   <= vertex_count;
            last_line    <= 1'b0;
            out_valid    <= 1'b1;
            vertex_count <= vertex_count + INDEX_BITS'(2);
            state        <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) begin
              a_o[i] <= t_r[i];
              b_o[i] <= b2[i];
            end
            base_index   <= vertex_count;
            last_line    <= 1'b1;
            out_valid    <= 1'b1;
            vertex_count <= vertex_count + INDEX_BITS'(2);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/arrow_glyph_generator_unit.sv @@
// Arrow glyph generator: one 3D segment in, shaft line and optional barb lines out.
// Input channel in_valid/in_ready carries start and tip (signed Q16.16); output
// channel out_valid/out_ready carries one line word: two endpoints, base_index
// and last_line. A segment no longer than min_length (or of zero length) gives
// only the shaft; otherwise shaft, then barb one, then barb two.
// The back end works one segment at a time; its root and divide units give one
// bit per cycle (a full arrow takes two roots and up to five divides).
// A two-word queue lets the front accept up to two segments while the back works.
// A stalled receiver holds the output register and the back end waits; the
// front keeps accepting until the queue is full.
// Reset (rst, synchronous) empties the queue, clears the vertex counter and
// loads the register defaults. Configuration: cfg_we/cfg_index/cfg_data, write
// only while idle; index three is ignored.
// Depends on agg_pkg, agg_front, agg_fifo, agg_back.
module arrow_glyph_generator_unit #(
  parameter int INDEX_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [agg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  agg_pkg::coord_t                start_x,
  input  agg_pkg::coord_t                start_y,
  input  agg_pkg::coord_t                start_z,
  input  agg_pkg::coord_t                tip_x,
  input  agg_pkg::coord_t                tip_y,
  input  agg_pkg::coord_t                tip_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output agg_pkg::coord_t                end_ax,
  output agg_pkg::coord_t                end_ay,
  output agg_pkg::coord_t                end_az,
  output agg_pkg::coord_t                end_bx,
  output agg_pkg::coord_t                end_by,
  output agg_pkg::coord_t                end_bz,
  output logic [INDEX_BITS-1:0]          base_index,
  output logic                           last_line
);
  import agg_pkg::*;

  cfg_t   cfg;
  entry_t f_entry;
  entry_t q_entry;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_length     <= MIN_LENGTH_RST;
      cfg.parallel_limit <= PARALLEL_LIMIT_RST;
      cfg.barb_ratio     <= BARB_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LENGTH:     cfg.min_length     <= cfg_data[15:0];
        CFG_PARALLEL_LIMIT: cfg.parallel_limit <= cfg_data[30:0];
        CFG_BARB_RATIO:     cfg.barb_ratio     <= cfg_data[16:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  agg_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .start_z  (start_z),
    .tip_x    (tip_x),
    .tip_y    (tip_y),
    .tip_z    (tip_z),
    .full     (full),
    .push     (push),
    .entry    (f_entry)
  );

  agg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_entry),
    .full  (full),
    .pop   (pop),
    .dout  (q_entry),
    .empty (empty)
  );

  agg_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .empty      (empty),
    .din        (q_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .end_ax     (end_ax),
    .end_ay     (end_ay),
    .end_az     (end_az),
    .end_bx     (end_bx),
    .end_by     (end_by),
    .end_bz     (end_bz),
    .base_index (base_index),
    .last_line  (last_line)
  );

endmodule
